/* rtl/ggvc_pkg.sv */
// Shared widths, constants and helper functions of the go-to-goal controller.
package ggvc_pkg;

    localparam int XW   = 36;   // CORDIC x/y width
    localparam int ZW   = 34;   // CORDIC angle width, 2^31 = pi
    localparam int MAW  = 37;   // serial multiplier multiplicand width
    localparam int MBW  = 18;   // serial multiplier multiplier width
    localparam int MPW  = MAW + MBW;

    localparam logic [MBW-1:0] INV_GAIN = MBW'(39797);
    localparam logic signed [XW-1:0] COS_X0 = XW'(64'sd652034048);
    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd2147483648);
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);

    typedef struct packed {
        logic start;
        logic rotate;
    } cordic_ctl_t;

    function automatic logic [ZW-1:0] atan_lookup(input logic [4:0] idx);
        logic [ZW-1:0] v;
        unique case (idx)
            5'd0:  v = ZW'(32'h20000000);
            5'd1:  v = ZW'(32'h12E4051E);
            5'd2:  v = ZW'(32'h09FB385B);
            5'd3:  v = ZW'(32'h051111D4);
            5'd4:  v = ZW'(32'h028B0D43);
            5'd5:  v = ZW'(32'h0145D7E1);
            5'd6:  v = ZW'(32'h00A2F61E);
            5'd7:  v = ZW'(32'h00517C55);
            5'd8:  v = ZW'(32'h0028BE53);
            5'd9:  v = ZW'(32'h00145F2F);
            5'd10: v = ZW'(32'h000A2F98);
            5'd11: v = ZW'(32'h000517CC);
            5'd12: v = ZW'(32'h00028BE6);
            5'd13: v = ZW'(32'h000145F3);
            5'd14: v = ZW'(32'h0000A2F9);
            5'd15: v = ZW'(32'h0000517C);
            5'd16: v = ZW'(32'h000028BE);
            5'd17: v = ZW'(32'h0000145F);
            5'd18: v = ZW'(32'h00000A2F);
            5'd19: v = ZW'(32'h00000517);
            5'd20: v = ZW'(32'h0000028B);
            5'd21: v = ZW'(32'h00000145);
            5'd22: v = ZW'(32'h000000A2);
            5'd23: v = ZW'(32'h00000051);
            default: v = '0;
        endcase
        return v;
    endfunction

    // symmetric saturation to +-lim
    function automatic logic [15:0] clamp_cmd(input logic signed [46:0] v,
                                              input logic [14:0] lim);
        logic signed [46:0] l;
        logic [15:0] r;
        l = $signed({32'b0, lim});
        if (v > l)
            r = {1'b0, lim};
        else if (v < -l)
            r = 16'(-l);
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

/* rtl/ggvc_mul_serial.sv */
// Bit-serial signed multiplier: one multiplier bit per cycle, shift and add.
module ggvc_mul_serial
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [ggvc_pkg::MAW-1:0]  a,
    input  logic [ggvc_pkg::MBW-1:0]         b,
    output logic                             busy,
    output logic                             done,
    output logic signed [ggvc_pkg::MPW-1:0]  prod
);
    import ggvc_pkg::*;

    localparam int CW = $clog2(MBW);

    logic signed [MPW-1:0] a_reg, a_next;
    logic [MBW-1:0]        b_reg, b_next;
    logic signed [MPW-1:0] acc_reg, acc_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next   = MPW'(a);
            b_next   = b;
            acc_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // top multiplier bit carries negative weight
            if (b_reg[0])
            begin
                if (cnt_reg == CW'(MBW-1))
                    acc_next = acc_reg - a_reg;
                else
                    acc_next = acc_reg + a_reg;
            end
            a_next   = a_reg <<< 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(MBW-1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign busy = run_reg;
    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* rtl/ggvc_cordic.sv */
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
module ggvc_cordic
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  ggvc_pkg::cordic_ctl_t           ctl,
    input  logic signed [ggvc_pkg::XW-1:0]  x0,
    input  logic signed [ggvc_pkg::XW-1:0]  y0,
    input  logic signed [ggvc_pkg::ZW-1:0]  z0,
    output logic                            busy,
    output logic                            done,
    output logic signed [ggvc_pkg::XW-1:0]  x,
    output logic signed [ggvc_pkg::ZW-1:0]  z
);
    import ggvc_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);

    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [IW-1:0]        cnt_reg, cnt_next;
    logic                 run_reg, run_next, rot_reg, rot_next;
    logic                 done_reg, done_next;
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    logic                 up;

    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign at = $signed(atan_lookup(5'(cnt_reg)));
    // vectoring drives y to zero, rotation drives z to zero
    assign up = rot_reg ? z_reg[ZW-1] : !y_reg[XW-1];

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        rot_next  = rot_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            x_next   = x0;
            y_next   = y0;
            z_next   = z0;
            cnt_next = '0;
            run_next = 1'b1;
            rot_next = ctl.rotate;
        end
        else if (run_reg)
        begin
            if (up)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == IW'(CORDIC_STEPS-1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rot_reg  <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rot_reg  <= rot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign busy = run_reg;
    assign done = done_reg;
    assign x    = x_reg;
    assign z    = z_reg;

endmodule

/* rtl/go_to_goal_velocity_controller.sv */
// Top level of the go-to-goal controller: sequencer, registers, CORDIC and multiplier.
//
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------------
//  input     | in_valid/in_ready   | func, robot_x, robot_y, robot_yaw, target_x/_y
//  output    | out_valid/out_ready | linear_cmd, angular_cmd, stopped
//  config    | APB psel/penable    | paddr, pwdata, prdata
//
// A pose transaction stores the robot pose when it is accepted. A follow transaction
// runs two CORDIC passes at one micro-rotation a cycle, vectoring for distance and
// bearing, then rotation for the heading-error cosine, and four products in the
// bit-serial multiplier: distance scaling, linear gain, cosine and angular gain.
// A follow outside the distance band ends after the check with a stopped result.
// Reset clears the pose, the registers to their defaults and the sequencer.
// A new transaction is taken while the last result waits in the output register.
module go_to_goal_velocity_controller
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic signed [23:0] robot_x,
    input  logic signed [23:0] robot_y,
    input  logic signed [15:0] robot_yaw,
    input  logic signed [23:0] target_x,
    input  logic signed [23:0] target_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] linear_cmd,
    output logic signed [15:0] angular_cmd,
    output logic               stopped
);
    import ggvc_pkg::*;

    localparam logic [2:0] REG_KP_LIN  = 3'd0;
    localparam logic [2:0] REG_KP_ANG  = 3'd1;
    localparam logic [2:0] REG_MAX_LIN = 3'd2;
    localparam logic [2:0] REG_MAX_ANG = 3'd3;
    localparam logic [2:0] REG_MIN_D   = 3'd4;
    localparam logic [2:0] REG_MAX_D   = 3'd5;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_VEC  = 4'd1;
    localparam logic [3:0] S_DMUL = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_COS  = 4'd4;
    localparam logic [3:0] S_PMUL = 4'd5;
    localparam logic [3:0] S_LMUL = 4'd6;
    localparam logic [3:0] S_AMUL = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [15:0] kp_lin_reg, kp_ang_reg;
    logic [14:0] max_lin_reg, max_ang_reg;
    logic [22:0] min_d_reg, max_d_reg;

    logic signed [23:0] pose_x_reg, pose_y_reg;
    logic [15:0]        pose_h_reg;
    logic               pose_valid_reg;

    logic [3:0]         state_reg, state_next;
    logic [30:0]        dist_reg, dist_next;
    logic [15:0]        err_reg, err_next;
    logic signed [17:0] cos_reg, cos_next;
    logic [15:0]        lin_reg, lin_next, ang_reg, ang_next;
    logic               stop_reg, stop_next;

    logic               out_valid_reg, out_valid_next;
    logic [15:0]        lin_out_reg, ang_out_reg;
    logic               stop_out_reg;

    cordic_ctl_t          cctl;
    logic signed [XW-1:0] cx0, cy0, cx, ca;
    logic signed [ZW-1:0] cz0, cz, ang_z;
    logic                 c_busy, c_done;

    logic                  m_start, m_busy, m_done;
    logic signed [MAW-1:0] m_a;
    logic [MBW-1:0]        m_b;
    logic signed [MPW-1:0] m_p, m_rnd8, m_rnd16, m_rnd23;

    logic               in_acc, cfg_wr;
    logic signed [24:0] dx, dy;
    logic [15:0]        bearing;
    logic signed [XW-1:0] xcl;

    assign pready   = 1'b1;
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign cfg_wr   = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_KP_LIN:  prdata = {16'b0, kp_lin_reg};
            REG_KP_ANG:  prdata = {16'b0, kp_ang_reg};
            REG_MAX_LIN: prdata = {17'b0, max_lin_reg};
            REG_MAX_ANG: prdata = {17'b0, max_ang_reg};
            REG_MIN_D:   prdata = {9'b0, min_d_reg};
            REG_MAX_D:   prdata = {9'b0, max_d_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_lin_reg  <= 16'd256;
            kp_ang_reg  <= 16'd256;
            max_lin_reg <= 15'd4096;
            max_ang_reg <= 15'd4096;
            min_d_reg   <= 23'd41;
            max_d_reg   <= 23'd409600;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_KP_LIN:  kp_lin_reg  <= pwdata[15:0];
                REG_KP_ANG:  kp_ang_reg  <= pwdata[15:0];
                REG_MAX_LIN: max_lin_reg <= pwdata[14:0];
                REG_MAX_ANG: max_ang_reg <= pwdata[14:0];
                REG_MIN_D:   min_d_reg   <= pwdata[22:0];
                REG_MAX_D:   max_d_reg   <= pwdata[22:0];
                default:     ;
            endcase
        end
    end

    // offset scaled by 256, mirrored into the right half plane
    assign dx = 25'(target_x) - 25'(pose_x_reg);
    assign dy = 25'(target_y) - 25'(pose_y_reg);

    // heading error cosine starts from the mirrored vector beyond a quarter turn
    assign ang_z = $signed({{2{err_reg[15]}}, err_reg, 16'b0});
    assign ca    = COS_X0;

    assign bearing = 16'((cz[31:0] + 32'h8000) >> 16);
    assign xcl     = cx[XW-1] ? '0 : cx;

    assign m_rnd8  = m_p + MPW'(128);
    assign m_rnd16 = m_p + MPW'(32768);
    assign m_rnd23 = m_p + MPW'(8388608);

    always_comb
    begin
        state_next = state_reg;
        dist_next  = dist_reg;
        err_next   = err_reg;
        cos_next   = cos_reg;
        lin_next   = lin_reg;
        ang_next   = ang_reg;
        stop_next  = stop_reg;
        cctl       = '0;
        cx0        = '0;
        cy0        = '0;
        cz0        = '0;
        m_start    = 1'b0;
        m_a        = '0;
        m_b        = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && func && pose_valid_reg)
                begin
                    cctl.start = 1'b1;
                    if (dx[24])
                    begin
                        cx0 = -($signed({{(XW-33){dx[24]}}, dx, 8'b0}));
                        cy0 = -($signed({{(XW-33){dy[24]}}, dy, 8'b0}));
                        cz0 = HALF_TURN;
                    end
                    else
                    begin
                        cx0 = $signed({{(XW-33){dx[24]}}, dx, 8'b0});
                        cy0 = $signed({{(XW-33){dy[24]}}, dy, 8'b0});
                    end
                    state_next = S_VEC;
                end
            end
            S_VEC:
            begin
                if (c_done)
                begin
                    err_next   = bearing - pose_h_reg;
                    m_start    = 1'b1;
                    m_a        = MAW'(xcl);
                    m_b        = INV_GAIN;
                    state_next = S_DMUL;
                end
            end
            S_DMUL:
            begin
                if (m_done)
                begin
                    dist_next  = m_rnd23[54:24];
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (dist_reg < {8'b0, min_d_reg} || dist_reg > {8'b0, max_d_reg})
                begin
                    lin_next   = '0;
                    ang_next   = '0;
                    stop_next  = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    stop_next   = 1'b0;
                    cctl.start  = 1'b1;
                    cctl.rotate = 1'b1;
                    if (ang_z > QUARTER_TURN)
                    begin
                        cx0 = -ca;
                        cz0 = ang_z - HALF_TURN;
                    end
                    else if (ang_z < -QUARTER_TURN)
                    begin
                        cx0 = -ca;
                        cz0 = ang_z + HALF_TURN;
                    end
                    else
                    begin
                        cx0 = ca;
                        cz0 = ang_z;
                    end
                    state_next = S_COS;
                end
            end
            S_COS:
            begin
                if (c_done)
                begin
                    cos_next   = 18'((cx + XW'(8192)) >>> 14);
                    m_start    = 1'b1;
                    m_a        = MAW'({6'b0, dist_reg});
                    m_b        = {2'b0, kp_lin_reg};
                    state_next = S_PMUL;
                end
            end
            S_PMUL:
            begin
                if (m_done)
                begin
                    m_start    = 1'b1;
                    m_a        = MAW'(m_rnd8[40:8]);
                    m_b        = cos_reg;
                    state_next = S_LMUL;
                end
            end
            S_LMUL:
            begin
                if (m_done)
                begin
                    lin_next   = clamp_cmd(47'($signed(m_rnd16[54:16])), max_lin_reg);
                    m_start    = 1'b1;
                    m_a        = MAW'($signed(err_reg));
                    m_b        = {2'b0, kp_ang_reg};
                    state_next = S_AMUL;
                end
            end
            S_AMUL:
            begin
                if (m_done)
                begin
                    ang_next   = clamp_cmd(m_rnd8[54:8], max_ang_reg);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pose_valid_reg <= 1'b0;
            pose_x_reg     <= '0;
            pose_y_reg     <= '0;
            pose_h_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (in_acc && !func)
            begin
                pose_x_reg     <= robot_x;
                pose_y_reg     <= robot_y;
                pose_h_reg     <= robot_yaw;
                pose_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        err_reg  <= err_next;
        cos_reg  <= cos_next;
        lin_reg  <= lin_next;
        ang_reg  <= ang_next;
        stop_reg <= stop_next;
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            lin_out_reg  <= lin_reg;
            ang_out_reg  <= ang_reg;
            stop_out_reg <= stop_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign linear_cmd  = lin_out_reg;
    assign angular_cmd = ang_out_reg;
    assign stopped     = stop_out_reg;

    ggvc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cctl),
        .x0    (cx0),
        .y0    (cy0),
        .z0    (cz0),
        .busy  (c_busy),
        .done  (c_done),
        .x     (cx),
        .z     (cz)
    );

    ggvc_mul_serial u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (m_start),
        .a     (m_a),
        .b     (m_b),
        .busy  (m_busy),
        .done  (m_done),
        .prod  (m_p)
    );

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(c_busy && m_busy))
        else $error("cordic and multiplier busy together");

    a_no_pose_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && func && !pose_valid_reg) |=> (state_reg == S_IDLE))
        else $error("follow without pose started work");

    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stopped) |-> (linear_cmd == 16'd0 && angular_cmd == 16'd0))
        else $error("stopped result carries nonzero command");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !out_ready) |=> (state_reg == S_OUT))
        else $error("result left while output register busy");

endmodule
